// ----- design/detection_result_packet_framer_top_assert.svh -----
// Assertion helpers shared by the framer modules.
// Every module that uses them has clk_i and rst_ni in scope.
`ifndef DETECTION_RESULT_PACKET_FRAMER_TOP_ASSERT_SVH
`define DETECTION_RESULT_PACKET_FRAMER_TOP_ASSERT_SVH

// Property that holds on every clock edge out of reset.
`define DRPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DRPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/drpf_pkg.sv -----
package drpf_pkg;

  localparam int unsigned MaxObjects = 10;
  localparam int unsigned CntW       = 4;

  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned ObjBytes  = 12;
  localparam int unsigned CrcBytes  = 2;
  localparam int unsigned JobW      = 8 * HdrBytes;
  localparam int unsigned LenW      = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] Magic     = 16'h4F59;
  localparam logic [7:0]  Version   = 8'h01;
  localparam logic [7:0]  Flags     = 8'h00;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] ScoreOne  = 16'h8000;

  typedef enum logic [1:0] {
    CmdHeader = 2'd0,
    CmdObject = 2'd1,
    CmdStatus = 2'd2
  } cmd_e;

  // one unit of work for the serializer
  typedef struct packed {
    logic            is_hdr;
    logic            crc_tail;
    logic [JobW-1:0] data;
  } job_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- design/detection_result_packet_framer_top.sv -----
// Detection-result packet framer. Each input request is classified by a
// front stage: a header request opens a packet (magic 0x4F59, version 1,
// flags 0, frame id, inference time, object count clamped to MaxObjects and
// the current dropped count, all little endian, 16 bytes); an object request
// adds 12 bytes (class, Q15 score, four box coordinates) while the header's
// count is not used up; a write-status request clears or bumps the dropped
// count; anything else is ignored. After the last announced object, or right
// after a header with a zero count, the CRC-16/CCITT-FALSE of the packet is
// sent low byte first and its high byte carries last. A fresh header drops
// an unfinished packet and restarts the checksum. Rate: the byte serializer
// sends one byte per cycle from its output register while the output is not
// stalled; status and ignored requests push no job. A two-entry job queue
// lets the input take requests every cycle until it holds two jobs.
module detection_result_packet_framer_top import drpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] frame_num_i,
  input  logic [31:0] infer_time_i,
  input  logic [15:0] object_total_i,
  input  logic [15:0] obj_class_i,
  input  logic signed [16:0] score_i,
  input  logic [15:0] box_x1_i,
  input  logic [15:0] box_y1_i,
  input  logic [15:0] box_x2_i,
  input  logic [15:0] box_y2_i,
  input  logic        write_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  logic accept;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  // stall on a full queue only
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // classify, track counts, pack header or object bytes
  drpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .frame_num_i    (frame_num_i),
    .infer_time_i   (infer_time_i),
    .object_total_i (object_total_i),
    .obj_class_i    (obj_class_i),
    .score_i        (score_i),
    .box_x1_i       (box_x1_i),
    .box_y1_i       (box_y1_i),
    .box_x2_i       (box_x2_i),
    .box_y2_i       (box_y2_i),
    .write_ok_i     (write_ok_i),
    .push_o         (push),
    .job_o          (push_job)
  );

  // decouples classification from byte output
  drpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // byte serializer with running CRC and registered output
  drpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// ----- design/drpf_front.sv -----
module drpf_front import drpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] frame_num_i,
  input  logic [31:0] infer_time_i,
  input  logic [15:0] object_total_i,
  input  logic [15:0] obj_class_i,
  input  logic signed [16:0] score_i,
  input  logic [15:0] box_x1_i,
  input  logic [15:0] box_y1_i,
  input  logic [15:0] box_x2_i,
  input  logic [15:0] box_y2_i,
  input  logic        write_ok_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [CntW-1:0] objects_left_q, objects_left_d;
  logic [15:0]     dropped_q, dropped_d;
  logic [15:0]     cnt16;
  logic [15:0]     score_sat;
  logic [15:0]     score_scaled;

  assign cnt16 = (object_total_i > 16'(MaxObjects)) ? 16'(MaxObjects) : object_total_i;

  // clamp to 0..1.0, then s*32767>>15 which is s-1 for any nonzero s
  always_comb begin
    if (score_i[16]) begin
      score_sat = '0;
    end else if (score_i[15:0] > ScoreOne) begin
      score_sat = ScoreOne;
    end else begin
      score_sat = score_i[15:0];
    end
    score_scaled = (score_sat == '0) ? '0 : score_sat - 16'd1;
  end

  always_comb begin
    objects_left_d = objects_left_q;
    dropped_d      = dropped_q;
    push_o         = 1'b0;
    job_o          = '0;
    if (accept_i) begin
      case (cmd_e'(cmd_i))
        CmdHeader: begin
          push_o         = 1'b1;
          job_o.is_hdr   = 1'b1;
          job_o.crc_tail = (cnt16 == '0);
          job_o.data     = {dropped_q, cnt16, infer_time_i, frame_num_i, Flags, Version, Magic};
          objects_left_d = cnt16[CntW-1:0];
        end
        CmdObject: begin
          if (objects_left_q != '0) begin
            push_o         = 1'b1;
            job_o.crc_tail = (objects_left_q == CntW'(1));
            job_o.data     = {32'h0, box_y2_i, box_x2_i, box_y1_i, box_x1_i,
                              score_scaled, obj_class_i};
            objects_left_d = objects_left_q - CntW'(1);
          end
        end
        CmdStatus: begin
          dropped_d = write_ok_i ? 16'h0 : dropped_q + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      objects_left_q <= '0;
      dropped_q      <= '0;
    end else begin
      objects_left_q <= objects_left_d;
      dropped_q      <= dropped_d;
    end
  end

endmodule

// ----- design/drpf_queue.sv -----
module drpf_queue import drpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);

  job_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntQW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntQW'(do_push) - CntQW'(do_pop);
    end
  end

`include "detection_result_packet_framer_top_assert.svh"
  `DRPF_ASSERT(a_no_push_full, !(push_i && full_o), "job pushed into full queue")
  `DRPF_ASSERT(a_count_bound, count_q <= CntQW'(QueueDepth), "queue count overflow")

endmodule

// ----- design/drpf_back.sv -----
module drpf_back import drpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic            busy_q, busy_d;
  logic [JobW-1:0] data_q, data_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [LenW-1:0] ndata_q, ndata_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  logic            out_room, emit, final_byte, data_phase, crc_lo;
  logic [7:0]      cur_byte;
  logic [15:0]     crc_next;
  logic [LenW-1:0] job_ndata;

  assign out_room   = !out_valid_q || !out_stall_i;
  assign emit       = busy_q && out_room;
  assign final_byte = (idx_q == len_q - LenW'(1));
  assign data_phase = (idx_q < ndata_q);
  assign crc_lo     = (idx_q == ndata_q);
  assign cur_byte   = data_phase ? data_q[7:0] : (crc_lo ? crc_q[7:0] : crc_q[15:8]);
  assign crc_next   = crc_byte(crc_q, data_q[7:0]);
  assign pop_o      = job_valid_i && (!busy_q || (emit && final_byte));
  assign job_ndata  = job_i.is_hdr ? LenW'(HdrBytes) : LenW'(ObjBytes);

  always_comb begin
    busy_d      = busy_q;
    data_d      = data_q;
    idx_d       = idx_q;
    ndata_d     = ndata_q;
    len_d       = len_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = !data_phase && !crc_lo;
      idx_d       = idx_q + LenW'(1);
      if (data_phase) begin
        data_d = {8'h00, data_q[JobW-1:8]};
        crc_d  = crc_next;
      end else if (!crc_lo) begin
        crc_d = CrcInit;
      end
      if (final_byte) begin
        busy_d = 1'b0;
      end
    end

    if (pop_o) begin
      busy_d  = 1'b1;
      data_d  = job_i.data;
      idx_d   = '0;
      ndata_d = job_ndata;
      len_d   = job_ndata + (job_i.crc_tail ? LenW'(CrcBytes) : LenW'(0));
      // a header restarts the checksum, also over an abandoned packet
      if (job_i.is_hdr) begin
        crc_d = CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      ndata_q     <= '0;
      len_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      ndata_q     <= ndata_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

`include "detection_result_packet_framer_top_assert.svh"
  `DRPF_ASSERT(a_idx_in_range, !busy_q || (idx_q < len_q), "byte index past job length")
  `DRPF_ASSERT_NEXT(a_crc_restart, emit && !data_phase && !crc_lo, crc_q == CrcInit,
                    "checksum not restarted after packet end")
  `DRPF_ASSERT_NEXT(a_held_byte, out_valid_q && out_stall_i, out_valid_q,
                    "stalled output byte dropped")

endmodule

// ----- tb/tb_detection_result_packet_framer_top.sv -----
module tb_detection_result_packet_framer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drpf_pkg::*;

  // cmd code with no meaning: the framer must swallow it
  localparam logic [1:0] CmdSpare = 2'd3;
  localparam int unsigned PktMax = 18;   // header + CRC with a zero count
  localparam int unsigned RandReqs = 210;
  localparam int unsigned DrainCycles = 64;

  // one input request, one field per port
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] frame_num;
    logic [31:0] infer_time;
    logic [15:0] object_total;
    logic [15:0] obj_class;
    logic [16:0] score;
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic        write_ok;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // directed row: request plus a hand-worked byte count and one known byte
  typedef struct packed {
    req_t       rq;
    logic [4:0] ref_n;
    logic [4:0] ref_idx;
    logic [7:0] ref_byte;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = '0;
  logic [31:0]        frame_num = '0;
  logic [31:0]        infer_time = '0;
  logic [15:0]        object_total = '0;
  logic [15:0]        obj_class = '0;
  logic signed [16:0] score = '0;
  logic [15:0]        box_x1 = '0;
  logic [15:0]        box_y1 = '0;
  logic [15:0]        box_x2 = '0;
  logic [15:0]        box_y2 = '0;
  logic               write_ok = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last;

  // framer model state
  logic [15:0] pkt_crc = CrcInit;
  logic [3:0]  objs_left = '0;
  logic [15:0] drop_cnt = '0;

  pkt_byte_t   pkt_bytes_q[$];        // bytes still owed by the framer
  logic [7:0]  last_pkt[PktMax];      // bytes predicted for the latest request
  int unsigned last_n;
  int unsigned busy_reqs = 0;         // requests that emit bytes or touch state
  int unsigned mismatches = 0;
  int unsigned bytes_seen = 0;
  bit          idle_on = 1'b1;
  dir_row_t    dir_tbl[24];

  detection_result_packet_framer_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .frame_num_i    (frame_num),
    .infer_time_i   (infer_time),
    .object_total_i (object_total),
    .obj_class_i    (obj_class),
    .score_i        (score),
    .box_x1_i       (box_x1),
    .box_y1_i       (box_y1),
    .box_x2_i       (box_x2),
    .box_y2_i       (box_y2),
    .write_ok_i     (write_ok),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_o         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------
  function automatic req_t hdr_req(logic [31:0] fid, logic [31:0] inf, logic [15:0] total);
    req_t r;
    r = '0;
    r.cmd          = CmdHeader;
    r.frame_num    = fid;
    r.infer_time   = inf;
    r.object_total = total;
    return r;
  endfunction

  function automatic req_t obj_req(logic [15:0] cls, logic [16:0] sc, logic [15:0] x1,
                                   logic [15:0] y1, logic [15:0] x2, logic [15:0] y2);
    req_t r;
    r = '0;
    r.cmd       = CmdObject;
    r.obj_class = cls;
    r.score     = sc;
    r.box_x1    = x1;
    r.box_y1    = y1;
    r.box_x2    = x2;
    r.box_y2    = y2;
    return r;
  endfunction

  function automatic req_t stat_req(logic ok);
    req_t r;
    r = '0;
    r.cmd      = CmdStatus;
    r.write_ok = ok;
    return r;
  endfunction

  // every field random, so the don't-care ports toggle as well
  function automatic req_t rand_req(logic [1:0] c);
    req_t r;
    r.cmd          = c;
    r.frame_num    = $urandom;
    r.infer_time   = $urandom;
    r.object_total = 16'($urandom);
    r.obj_class    = 16'($urandom);
    r.score        = 17'($urandom);
    r.box_x1       = 16'($urandom);
    r.box_y1       = 16'($urandom);
    r.box_x2       = 16'($urandom);
    r.box_y2       = 16'($urandom);
    r.write_ok     = 1'($urandom);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Framer prediction
  // ---------------------------------------------------------------------

  // CCITT CRC, one message bit at a time into the top of the register
  function automatic logic [15:0] crc_feed(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  task automatic owe_byte(logic [7:0] b, logic lst);
    pkt_byte_t pb;
    pb.data = b;
    pb.last = lst;
    pkt_bytes_q.push_back(pb);
    if (last_n < PktMax) last_pkt[last_n] = b;
    last_n++;
  endtask

  // little endian field, folded into the running CRC
  task automatic owe_field(logic [31:0] v, int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) begin
      owe_byte(v[8*i +: 8], 1'b0);
      pkt_crc = crc_feed(pkt_crc, v[8*i +: 8]);
    end
  endtask

  task automatic owe_crc();
    owe_byte(pkt_crc[7:0], 1'b0);
    owe_byte(pkt_crc[15:8], 1'b1);
    pkt_crc = CrcInit;
  endtask

  task automatic frame_request(input req_t r);
    logic [15:0] cnt;
    int          s;
    logic [15:0] q15;
    last_n = 0;
    case (r.cmd)
      CmdHeader: begin
        cnt = (r.object_total > MaxObjects) ? 16'(MaxObjects) : r.object_total;
        // a header always restarts the checksum, open packet or not
        pkt_crc = CrcInit;
        owe_field(32'(Magic), 2);
        owe_field(32'(Version), 1);
        owe_field(32'(Flags), 1);
        owe_field(r.frame_num, 4);
        owe_field(r.infer_time, 4);
        owe_field(32'(cnt), 2);
        owe_field(32'(drop_cnt), 2);
        objs_left = cnt[3:0];
        if (objs_left == 0) owe_crc();
      end
      CmdObject: begin
        if (objs_left != 0) begin
          // signed Q1.15 clamped to 0..1.0, scaled by 32767/32768, truncated
          s = int'($signed(r.score));
          if (s < 0) s = 0;
          if (s > int'(ScoreOne)) s = int'(ScoreOne);
          q15 = 16'((s * 32767) >>> 15);
          owe_field(32'(r.obj_class), 2);
          owe_field(32'(q15), 2);
          owe_field(32'(r.box_x1), 2);
          owe_field(32'(r.box_y1), 2);
          owe_field(32'(r.box_x2), 2);
          owe_field(32'(r.box_y2), 2);
          objs_left = objs_left - 4'd1;
          if (objs_left == 0) owe_crc();
        end
      end
      CmdStatus: begin
        if (r.write_ok) drop_cnt = '0;
        else drop_cnt = drop_cnt + 16'd1;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Request side: optional gap, then hold the request until taken
  // ---------------------------------------------------------------------
  task automatic send_req(input req_t r);
    if (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= r.cmd;
    frame_num    <= r.frame_num;
    infer_time   <= r.infer_time;
    object_total <= r.object_total;
    obj_class    <= r.obj_class;
    score        <= r.score;
    box_x1       <= r.box_x1;
    box_y1       <= r.box_y1;
    box_x2       <= r.box_x2;
    box_y2       <= r.box_y2;
    write_ok     <= r.write_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_request(r);
    if (last_n != 0 || r.cmd == CmdStatus) busy_reqs++;
  endtask

  // sender holds off until the framer has paid out every byte owed
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pkt_bytes_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Byte side: random back-pressure and the byte checker
  // ---------------------------------------------------------------------
  always @(posedge clk) out_stall <= idle_on && ($urandom_range(99) < 30);

  always @(posedge clk) begin : byte_check
    pkt_byte_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pkt_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %b", out_byte, out_last));
      end else begin
        want = pkt_bytes_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %0d: data %02h, want %02h",
                                    bytes_seen, out_byte, want.data));
        if (out_last !== want.last)
          report_mismatch($sformatf("byte %0d: last %b, want %b",
                                    bytes_seen, out_last, want.last));
      end
      bytes_seen++;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stim
    req_t        r;
    int unsigned objs;
    int unsigned stop_at;
    bit          paused;

    // Directed pass: count extremes and clamping, score clamp corners,
    // stray objects, the spare cmd code, dropped-count bookkeeping and a
    // header that abandons an open packet.
    dir_tbl = '{
      '{hdr_req(32'hFFFF_FFFF, 32'h0, 16'd0), 5'd18, 5'd0, 8'h59},
      '{hdr_req(32'h0, 32'hFFFF_FFFF, 16'd1), 5'd16, 5'd8, 8'hFF},
      '{obj_req(16'hFFFF, 17'h08000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
        5'd14, 5'd3, 8'h7F},
      '{obj_req(16'h0, 17'h0, 16'h0, 16'h0, 16'h0, 16'h0), 5'd0, 5'd0, 8'h00},
      '{rand_req(CmdSpare), 5'd0, 5'd0, 8'h00},
      '{stat_req(1'b0), 5'd0, 5'd0, 8'h00},
      '{stat_req(1'b0), 5'd0, 5'd0, 8'h00},
      '{hdr_req(32'h1234_5678, 32'h0000_ABCD, 16'hFFFF), 5'd16, 5'd14, 8'h02},
      '{obj_req(16'd0, 17'h00000, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd3, 8'h00},
      '{obj_req(16'd1, 17'h10000, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd2, 8'h00},
      '{obj_req(16'd2, 17'h1FFFF, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd3, 8'h00},
      '{obj_req(16'd3, 17'h0FFFF, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd3, 8'h7F},
      '{obj_req(16'd4, 17'h07FFF, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd2, 8'hFE},
      '{obj_req(16'd5, 17'h00001, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd2, 8'h00},
      '{obj_req(16'd6, 17'h00002, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd2, 8'h01},
      '{obj_req(16'd7, 17'h04000, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd3, 8'h3F},
      '{obj_req(16'd8, 17'h08001, 16'h0, 16'h0, 16'h0, 16'h0), 5'd12, 5'd2, 8'hFF},
      '{obj_req(16'd9, 17'h08000, 16'h0, 16'h0, 16'h0, 16'h0), 5'd14, 5'd0, 8'h09},
      '{hdr_req(32'd1, 32'd2, 16'd3), 5'd16, 5'd12, 8'h03},
      '{obj_req(16'hA5A5, 17'd100, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h5A5A),
        5'd12, 5'd0, 8'hA5},
      '{hdr_req(32'h0, 32'h0, 16'd0), 5'd18, 5'd1, 8'h4F},
      '{stat_req(1'b1), 5'd0, 5'd0, 8'h00},
      '{hdr_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd11), 5'd16, 5'd12, 8'h0A},
      '{obj_req(16'h0102, 17'h04000, 16'h1234, 16'h0, 16'hFFFF, 16'h8000),
        5'd12, 5'd4, 8'h34}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i].rq);
      if (last_n != dir_tbl[i].ref_n)
        report_mismatch($sformatf("row %0d: %0d bytes predicted, worked out %0d",
                                  i, last_n, dir_tbl[i].ref_n));
      else if (last_n != 0 && last_pkt[dir_tbl[i].ref_idx] !== dir_tbl[i].ref_byte)
        report_mismatch($sformatf("row %0d: byte %0d predicted %02h, worked out %02h",
                                  i, dir_tbl[i].ref_idx, last_pkt[dir_tbl[i].ref_idx],
                                  dir_tbl[i].ref_byte));
    end
    drain_pending();

    // Random pass: mostly complete packets with random content, some cut
    // short by a fresh header, plus status reports, stray objects and the
    // spare cmd code as noise.
    idle_on = 1'b1;
    paused  = 1'b0;
    stop_at = busy_reqs + RandReqs;
    while (busy_reqs < stop_at) begin
      // a stretch with no gaps on either side
      idle_on = !(busy_reqs + 140 >= stop_at && busy_reqs + 80 < stop_at);
      if (!paused && busy_reqs + RandReqs / 2 >= stop_at) begin
        drain_pending();
        paused = 1'b1;
      end
      case ($urandom_range(19))
        0, 1: send_req(rand_req(CmdStatus));
        2:    send_req(rand_req(CmdObject));
        3:    send_req(rand_req(CmdSpare));
        default: begin
          r = rand_req(CmdHeader);
          case ($urandom_range(9))
            0:       ;                                   // full 16-bit count
            1, 2:    r.object_total = 16'($urandom_range(MaxObjects + 1, 15));
            default: r.object_total = 16'($urandom_range(0, MaxObjects));
          endcase
          send_req(r);
          objs = 32'(objs_left);
          if ($urandom_range(9) == 0) objs = $urandom_range(0, objs);   // cut short
          repeat (objs) begin
            if ($urandom_range(19) == 0) send_req(rand_req(CmdStatus));
            r = rand_req(CmdObject);
            case ($urandom_range(7))
              0:       ;                                 // any 17-bit pattern
              1:       r.score = 17'(ScoreOne);
              2:       r.score = 17'h00000;
              default: r.score = 17'($urandom_range(0, 32768));
            endcase
            send_req(r);
          end
        end
      endcase
    end

    drain_pending();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout with %0d bytes still owed", pkt_bytes_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
